### hw/rtl/lz_rle_history_decompressor_defines.svh
// Assertion macros shared by the decompressor RTL.
`ifndef LZ_RLE_HISTORY_DECOMPRESSOR_DEFINES_SVH
`define LZ_RLE_HISTORY_DECOMPRESSOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define LZRH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define LZRH_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LZRH_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZRH_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### hw/rtl/lzrh_pkg.sv
`timescale 1ns / 1ps

package lzrh_pkg;

    localparam int HISTORY_DEPTH = 65536;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int POS_W         = ADDR_W + 1;
    localparam int SUM_W         = 17;

    // Request kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_PULL  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_UNEXP = 2'd3;

    // Result status codes
    localparam logic [3:0] ST_ACCEPT   = 4'd0;
    localparam logic [3:0] ST_BYTE     = 4'd1;
    localparam logic [3:0] ST_NEED     = 4'd2;
    localparam logic [3:0] ST_FINISHED = 4'd3;
    localparam logic [3:0] ST_BADCMD   = 4'd4;
    localparam logic [3:0] ST_BADREAD  = 4'd5;
    localparam logic [3:0] ST_OVERFLOW = 4'd6;
    localparam logic [3:0] ST_TRUNC    = 4'd7;
    localparam logic [3:0] ST_UNEXP    = 4'd8;

    // Result of one accepted transaction, as decided by the command stage
    typedef struct packed {
        logic [3:0]        status;
        logic [7:0]        data;
        logic              run_end;
        logic              use_ram;
        logic              invert;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
    } t_issue;

    // History write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

endpackage

### hw/rtl/lzrh_if.sv
`timescale 1ns / 1ps

interface lzrh_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] in_byte;

    modport source (output valid, output kind, output in_byte, input ready);
    modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

interface lzrh_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output status, output out_byte, output run_end,
                    input ready);
    modport sink   (input valid, input status, input out_byte, input run_end,
                    output ready);
endinterface

### hw/rtl/lzrh_ram.sv
`timescale 1ns / 1ps

module lzrh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/lzrh_cmd.sv
`timescale 1ns / 1ps
`include "lz_rle_history_decompressor_defines.svh"

module lzrh_cmd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_byte,
    output lzrh_pkg::t_issue    o_issue
);

    localparam logic [3:0] PH_HEADER   = 4'd0;
    localparam logic [3:0] PH_EXTCNT   = 4'd1;
    localparam logic [3:0] PH_OPER1    = 4'd2;
    localparam logic [3:0] PH_OPER2    = 4'd3;
    localparam logic [3:0] PH_LITWAIT  = 4'd4;
    localparam logic [3:0] PH_LITREADY = 4'd5;
    localparam logic [3:0] PH_EMIT     = 4'd6;
    localparam logic [3:0] PH_DONE     = 4'd7;
    localparam logic [3:0] PH_BADCMD   = 4'd8;
    localparam logic [3:0] PH_BADREAD  = 4'd9;
    localparam logic [3:0] PH_OVERFLOW = 4'd10;
    localparam logic [3:0] PH_TRUNC    = 4'd11;

    localparam logic [2:0] OP_LIT  = 3'd0;
    localparam logic [2:0] OP_FILL = 3'd1;
    localparam logic [2:0] OP_ALT  = 3'd2;
    localparam logic [2:0] OP_INC  = 3'd3;
    localparam logic [2:0] OP_COPY = 3'd4;
    localparam logic [2:0] OP_INV  = 3'd5;
    localparam logic [2:0] OP_REL  = 3'd6;
    localparam logic [2:0] OP_EXT  = 3'd7;

    logic [3:0]               r_phase, n_phase;
    logic [2:0]               r_op, n_op;
    logic [10:0]              r_len, n_len;
    logic [10:0]              r_done, n_done;
    logic [7:0]               r_fill_lo, n_fill_lo;
    logic [7:0]               r_fill_hi, n_fill_hi;
    logic [15:0]              r_src, n_src;
    logic                     r_alt, n_alt;
    logic [lzrh_pkg::POS_W-1:0] r_pos, n_pos;

    logic [lzrh_pkg::SUM_W-1:0] w_addr;
    logic [lzrh_pkg::SUM_W-1:0] w_rel;
    logic [10:0]                w_done_inc;
    logic                       w_term;
    lzrh_pkg::t_issue           w_issue;

    assign w_addr     = lzrh_pkg::SUM_W'(r_src) + lzrh_pkg::SUM_W'(r_done);
    assign w_rel      = lzrh_pkg::SUM_W'(r_pos) - lzrh_pkg::SUM_W'(i_byte);
    assign w_done_inc = r_done + 11'd1;
    assign w_term     = (r_phase == PH_DONE) || (r_phase == PH_BADCMD) ||
                        (r_phase == PH_BADREAD) || (r_phase == PH_OVERFLOW) ||
                        (r_phase == PH_TRUNC);

    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_len     = r_len;
        n_done    = r_done;
        n_fill_lo = r_fill_lo;
        n_fill_hi = r_fill_hi;
        n_src     = r_src;
        n_alt     = r_alt;
        n_pos     = r_pos;

        w_issue         = '0;
        w_issue.status  = lzrh_pkg::ST_ACCEPT;
        w_issue.rd_addr = w_addr[lzrh_pkg::ADDR_W-1:0];
        w_issue.wr_addr = r_pos[lzrh_pkg::ADDR_W-1:0];

        case (r_phase)
            PH_DONE:     w_issue.status = lzrh_pkg::ST_FINISHED;
            PH_BADCMD:   w_issue.status = lzrh_pkg::ST_BADCMD;
            PH_BADREAD:  w_issue.status = lzrh_pkg::ST_BADREAD;
            PH_OVERFLOW: w_issue.status = lzrh_pkg::ST_OVERFLOW;
            PH_TRUNC:    w_issue.status = lzrh_pkg::ST_TRUNC;
            default: begin
                if (i_kind == lzrh_pkg::KIND_UNEXP) begin
                    w_issue.status = lzrh_pkg::ST_UNEXP;
                end else if (r_phase inside {PH_LITREADY, PH_EMIT}) begin
                    if (i_kind != lzrh_pkg::KIND_PULL) begin
                        w_issue.status = lzrh_pkg::ST_UNEXP;
                    end else if (r_pos >= lzrh_pkg::POS_W'(lzrh_pkg::HISTORY_DEPTH)) begin
                        n_phase        = PH_OVERFLOW;
                        w_issue.status = lzrh_pkg::ST_OVERFLOW;
                    end else if (r_op inside {OP_COPY, OP_INV, OP_REL, OP_EXT} &&
                                 w_addr >= lzrh_pkg::SUM_W'(r_pos)) begin
                        n_phase        = PH_BADREAD;
                        w_issue.status = lzrh_pkg::ST_BADREAD;
                    end else begin
                        w_issue.status  = lzrh_pkg::ST_BYTE;
                        w_issue.run_end = (w_done_inc >= r_len);
                        case (r_op)
                            OP_LIT, OP_FILL: w_issue.data = r_fill_lo;
                            OP_ALT: begin
                                w_issue.data = r_alt ? r_fill_hi : r_fill_lo;
                                n_alt        = ~r_alt;
                            end
                            OP_INC: w_issue.data = r_fill_lo + r_done[7:0];
                            default: begin
                                // history byte arrives from the RAM next cycle
                                w_issue.use_ram = 1'b1;
                                w_issue.invert  = (r_op == OP_INV);
                            end
                        endcase
                        n_pos  = r_pos + lzrh_pkg::POS_W'(1);
                        n_done = w_done_inc;
                        if (w_issue.run_end) begin
                            n_phase = PH_HEADER;
                        end else if (r_op == OP_LIT) begin
                            n_phase = PH_LITWAIT;
                        end
                    end
                end else if (i_kind == lzrh_pkg::KIND_PULL) begin
                    w_issue.status = lzrh_pkg::ST_NEED;
                end else if (i_kind == lzrh_pkg::KIND_END) begin
                    if (r_phase == PH_HEADER) begin
                        n_phase        = PH_DONE;
                        w_issue.status = lzrh_pkg::ST_FINISHED;
                    end else begin
                        n_phase        = PH_TRUNC;
                        w_issue.status = lzrh_pkg::ST_TRUNC;
                    end
                end else begin
                    case (r_phase)
                        PH_HEADER: begin
                            if (i_byte == 8'hff) begin
                                n_phase        = PH_DONE;
                                w_issue.status = lzrh_pkg::ST_FINISHED;
                            end else if (i_byte[7:5] == OP_EXT) begin
                                n_op = i_byte[4:2];
                                if (i_byte[4:2] == OP_EXT) begin
                                    n_phase        = PH_BADCMD;
                                    w_issue.status = lzrh_pkg::ST_BADCMD;
                                end else begin
                                    n_len   = {1'b0, i_byte[1:0], 8'h00};
                                    n_phase = PH_EXTCNT;
                                end
                            end else begin
                                n_op    = i_byte[7:5];
                                n_len   = 11'(i_byte[4:0]) + 11'd1;
                                n_done  = '0;
                                n_alt   = 1'b0;
                                n_phase = (i_byte[7:5] == OP_LIT) ? PH_LITWAIT : PH_OPER1;
                            end
                        end
                        PH_EXTCNT: begin
                            n_len   = r_len + 11'(i_byte) + 11'd1;
                            n_done  = '0;
                            n_alt   = 1'b0;
                            n_phase = (r_op == OP_LIT) ? PH_LITWAIT : PH_OPER1;
                        end
                        PH_OPER1: begin
                            n_fill_lo = i_byte;
                            if (r_op == OP_REL) begin
                                n_src   = w_rel[15:0];
                                n_phase = PH_EMIT;
                            end else if (r_op == OP_FILL || r_op == OP_INC) begin
                                n_phase = PH_EMIT;
                            end else begin
                                n_phase = PH_OPER2;
                            end
                        end
                        PH_OPER2: begin
                            if (r_op == OP_ALT) begin
                                n_fill_hi = i_byte;
                            end else begin
                                n_src = {i_byte, r_fill_lo};
                            end
                            n_phase = PH_EMIT;
                        end
                        PH_LITWAIT: begin
                            n_fill_lo = i_byte;
                            n_phase   = PH_LITREADY;
                        end
                        default: w_issue.status = lzrh_pkg::ST_UNEXP;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_op      <= '0;
            r_len     <= '0;
            r_done    <= '0;
            r_fill_lo <= '0;
            r_fill_hi <= '0;
            r_src     <= '0;
            r_alt     <= 1'b0;
            r_pos     <= '0;
        end else if (i_acc) begin
            r_phase   <= n_phase;
            r_op      <= n_op;
            r_len     <= n_len;
            r_done    <= n_done;
            r_fill_lo <= n_fill_lo;
            r_fill_hi <= n_fill_hi;
            r_src     <= n_src;
            r_alt     <= n_alt;
            r_pos     <= n_pos;
        end
    end

    assign o_issue = w_issue;

    `LZRH_ASSERT(a_pos_advance, i_clk, i_rst_n, (i_acc && w_issue.status == lzrh_pkg::ST_BYTE) |=> (r_pos == $past(r_pos) + lzrh_pkg::POS_W'(1)), "position did not advance on an output byte")
    `LZRH_ASSERT(a_term_sticky, i_clk, i_rst_n, w_term |=> (w_term && $stable(r_phase)), "finished or error state left before reset")
    `LZRH_ASSERT(a_run_bound, i_clk, i_rst_n, (r_phase == PH_EMIT || r_phase == PH_LITREADY) |-> (r_done < r_len), "run count passed run length while emitting")

endmodule

### hw/rtl/lzrh_emit.sv
`timescale 1ns / 1ps
`include "lz_rle_history_decompressor_defines.svh"

module lzrh_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  lzrh_pkg::t_issue   i_issue,
    input  logic [7:0]         i_rdata,
    output logic               o_ready,
    output lzrh_pkg::t_wr      o_wr,
    lzrh_out_if.source         o_out
);

    logic                        r_valid;
    logic [3:0]                  r_status;
    logic [7:0]                  r_data;
    logic                        r_run_end;
    logic                        r_use_ram;
    logic                        r_invert;
    logic                        r_fwd;
    logic [7:0]                  r_fwd_data;
    logic [lzrh_pkg::ADDR_W-1:0] r_wr_addr;

    logic [7:0]    w_hist;
    logic [7:0]    w_byte;
    logic          w_leave;
    lzrh_pkg::t_wr w_wr;

    assign w_hist  = r_fwd ? r_fwd_data : i_rdata;
    assign w_byte  = r_use_ram ? (w_hist ^ {8{r_invert}}) : r_data;
    assign w_leave = r_valid && o_out.ready;
    assign o_ready = !r_valid || o_out.ready;

    // Commit the byte to history as it leaves the output stage.
    assign w_wr.en   = w_leave && (r_status == lzrh_pkg::ST_BYTE);
    assign w_wr.addr = r_wr_addr;
    assign w_wr.data = w_byte;
    assign o_wr      = w_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_acc) begin
            r_valid <= 1'b1;
        end else if (w_leave) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_status   <= i_issue.status;
            r_data     <= i_issue.data;
            r_run_end  <= i_issue.run_end;
            r_use_ram  <= i_issue.use_ram;
            r_invert   <= i_issue.invert;
            r_wr_addr  <= i_issue.wr_addr;
            // the RAM returns old data for the entry written this cycle: bypass it
            r_fwd      <= w_wr.en && (i_issue.rd_addr == r_wr_addr);
            r_fwd_data <= w_byte;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.status   = r_status;
    assign o_out.out_byte = (r_status == lzrh_pkg::ST_BYTE) ? w_byte : 8'h00;
    assign o_out.run_end  = r_run_end;

    `LZRH_ASSERT(a_no_overwrite, i_clk, i_rst_n, (i_acc && r_valid) |-> o_out.ready, "new transaction accepted over a held result")
    `LZRH_ASSERT_NEVER(a_ram_only_bytes, i_clk, i_rst_n, r_valid && r_use_ram && (r_status != lzrh_pkg::ST_BYTE), "history read issued for a non-byte result")
    `LZRH_ASSERT(a_hold_result, i_clk, i_rst_n, (r_valid && !o_out.ready) |=> (r_valid && $stable(r_status) && $stable(r_run_end) && $stable(o_out.out_byte)), "held result changed while output not ready")

endmodule

### hw/rtl/lz_rle_history_decompressor.sv
`timescale 1ns / 1ps

// LZ/RLE history decompressor. Feed compressed bytes (kind 0), pull
// decompressed bytes (kind 1) and mark the end of input (kind 2) on i_in;
// every transaction returns exactly one result on o_out with a status code,
// the byte when the status is "out byte", and run_end on the last byte of a
// command. The block takes one transaction per clock cycle and returns its
// result in the next cycle through the output register; a held result stalls
// i_in only while o_out is not ready. Copy commands read the output history
// from a 2^16 x 8 RAM: the read is issued as the pull is accepted, and the
// byte being retired from the output register in the same cycle is bypassed
// around the RAM, so a copy one byte back still runs at full rate. The
// history needs no clearing after reset; reads of unwritten positions are
// caught and reported as a bad history read. Finished and error states hold
// until reset.
module lz_rle_history_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzrh_in_if.sink     i_in,
    lzrh_out_if.source  o_out
);

    lzrh_pkg::t_issue w_issue;
    lzrh_pkg::t_wr    w_wr;
    logic             w_ready;
    logic             w_acc;
    logic [7:0]       w_rdata;

    assign w_acc      = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    // Decode the command stream and decide every result.
    lzrh_cmd u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_kind  (i_in.kind),
        .i_byte  (i_in.in_byte),
        .o_issue (w_issue)
    );

    // Output history; read issued on acceptance, written on retirement.
    lzrh_ram #(
        .WIDTH (8),
        .DEPTH (lzrh_pkg::HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_acc),
        .i_raddr (w_issue.rd_addr),
        .o_rdata (w_rdata)
    );

    // Output register, bypass and history write-back.
    lzrh_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_issue (w_issue),
        .i_rdata (w_rdata),
        .o_ready (w_ready),
        .o_wr    (w_wr),
        .o_out   (o_out)
    );

endmodule
